### design/i2crm_pkg.sv
// Package for the I2C register master: commands, config indices, tick and result records and sizes.
// Used by the top level, the sequencer and the testbench checker; depends on nothing.
package i2crm_pkg;
  localparam int MaxLenDefault = 16;
  localparam int GuardResetDefault = 5000;
  localparam logic [15:0] GuardReset = 16'd5000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_GUARD  = 1'b1;

  // One accepted tick as it travels from the front part to the sequencer.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_addr;
    logic [7:0] data_byte;
    logic [3:0] buf_index;
    logic [4:0] length;
    logic       sda_in;
  } tick_t;

  // One result of a tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       done_res;
    logic       nack_error;
  } res_t;
endpackage

### design/i2c_register_master.sv
// Top level of the I2C register master: input queue, sequencer, result queue.
// Depends on i2crm_pkg, i2crm_queue and i2crm_seq.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  input    | push / full        | cmd reg_addr data_byte buf_index length sda_in
//  result   | pop / empty        | scl_level sda_level busy_res rd_byte rd_valid
//           |                    | done_res nack_error
//  config   | cfg_valid/cfg_ready| cfg_index cfg_data
//
// The sequencer takes one tick per step, so one tick can be accepted every
// cycle while results are popped and the result queue has room. A tick waits
// in the input queue until the sequencer steps on it; its result is written into the result queue on that step.
// Reset puts the bus lines released and empties both queues. When the
// result queue is full the sequencer holds, and the input queue fills up
// behind it; full then stays high until a result is popped.
module i2c_register_master #(
  parameter int MaxLen = i2crm_pkg::MaxLenDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd,
  input  logic [7:0] reg_addr,
  input  logic [7:0] data_byte,
  input  logic [3:0] buf_index,
  input  logic [4:0] length,
  input  logic       sda_in,
  output logic       empty,
  input  logic       pop,
  output logic       scl_level,
  output logic       sda_level,
  output logic       busy_res,
  output logic [7:0] rd_byte,
  output logic       rd_valid,
  output logic       done_res,
  output logic       nack_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [15:0] cfg_data
);
  import i2crm_pkg::*;

  tick_t in_item, tick;
  res_t  res, out_item;
  logic  in_empty, out_full, go;
  logic [6:0]  target_address;
  logic [15:0] guard_ticks;

  assign in_item = '{cmd: cmd, reg_addr: reg_addr, data_byte: data_byte,
                     buf_index: buf_index, length: length, sda_in: sda_in};

  i2crm_queue #(.Width($bits(tick_t))) u_in_q (
    .clk(clk), .rst(rst), .wr(push), .wdata(in_item), .full(full),
    .rd(go), .rdata(tick), .empty(in_empty)
  );

  // The sequencer steps when a tick waits and there is room for its result.
  assign go = !in_empty && !out_full;

  i2crm_seq #(.MaxLen(MaxLen)) u_seq (
    .clk(clk), .rst(rst), .go(go), .tick(tick),
    .target_address(target_address), .guard_ticks(guard_ticks), .res(res)
  );

  i2crm_queue #(.Width($bits(res_t))) u_out_q (
    .clk(clk), .rst(rst), .wr(go), .wdata(res), .full(out_full),
    .rd(pop), .rdata(out_item), .empty(empty)
  );

  assign scl_level  = out_item.scl_level;
  assign sda_level  = out_item.sda_level;
  assign busy_res   = out_item.busy_res;
  assign rd_byte    = out_item.rd_byte;
  assign rd_valid   = out_item.rd_valid;
  assign done_res   = out_item.done_res;
  assign nack_error = out_item.nack_error;

  // Configuration registers are always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= 7'd0;
      guard_ticks    <= GuardReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET: target_address <= cfg_data[6:0];
        CFG_GUARD:  guard_ticks    <= cfg_data;
        default:    guard_ticks    <= guard_ticks;
      endcase
    end
  end
endmodule

### design/i2crm_queue.sv
// Small two-entry queue used between the front part, the sequencer and the ports.
// Depends on nothing but its width parameter.
module i2crm_queue #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [Width-1:0] rdata,
  output logic             empty
);
  logic [Width-1:0] mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) begin
        wptr <= ~wptr;
      end
      if (rd && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

### design/i2crm_seq.sv
// Bit sequencer of the I2C register master: one phase step for each tick.
// Depends on i2crm_pkg; holds the transmit buffer.
module i2crm_seq #(
  parameter int MaxLen = i2crm_pkg::MaxLenDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  i2crm_pkg::tick_t    tick,
  input  logic [6:0]          target_address,
  input  logic [15:0]         guard_ticks,
  output i2crm_pkg::res_t     res
);
  import i2crm_pkg::*;

  localparam int LW = $clog2(MaxLen + 1);
  localparam int IW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_TX0, PH_TX1, PH_TX2,
    PH_WA0, PH_WA1, PH_RX0, PH_RX1, PH_AK0, PH_AK1, PH_AK2, PH_NK0,
    PH_NK1, PH_SP0, PH_SP1, PH_DONE, PH_GUARD
  } phase_t;

  typedef enum logic [2:0] {
    STG_ADDR_W, STG_REG, STG_WDATA, STG_ADDR_R, STG_RDATA
  } stage_t;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [LW-1:0] byte_count, byte_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  saved_reg, saved_reg_next;
  logic [LW-1:0] saved_length, saved_length_next;
  logic        read_mode, read_mode_next;
  logic        error_flag, error_flag_next;
  logic [15:0] guard_count, guard_count_next;
  logic        scl_reg, scl_next, sda_reg, sda_next;
  logic [7:0]  tx_buffer [MaxLen];
  logic        busy, rdv, done;
  logic [7:0]  rdb;
  logic [8:0]  shl;
  logic [LW-1:0] bc_inc;
  logic        buf_end;
  phase_t      ph;

  always_ff @(posedge clk) begin
    if (go && phase == PH_IDLE && tick.cmd == CMD_LOAD
        && 32'(tick.buf_index) < MaxLen) begin
      tx_buffer[IW'(tick.buf_index)] <= tick.data_byte;
    end
  end

  always_comb begin
    phase_next = phase; stage_next = stage;
    bit_count_next = bit_count; byte_count_next = byte_count;
    shift_reg_next = shift_reg; saved_reg_next = saved_reg;
    saved_length_next = saved_length; read_mode_next = read_mode;
    error_flag_next = error_flag; guard_count_next = guard_count;
    scl_next = scl_reg; sda_next = sda_reg;
    rdv = 1'b0; rdb = 8'd0; done = 1'b0;
    shl = 9'd0; bc_inc = byte_count + LW'(1); buf_end = 1'b0;
    ph = phase;
    if (phase == PH_IDLE && (tick.cmd == CMD_WRITE || tick.cmd == CMD_READ)) begin
      saved_reg_next = tick.reg_addr;
      if (32'(tick.length) > MaxLen) begin
        saved_length_next = LW'(MaxLen);
      end else begin
        saved_length_next = LW'(tick.length);
      end
      read_mode_next = (tick.cmd == CMD_READ);
      error_flag_next = 1'b0;
      byte_count_next = '0;
      bit_count_next = 4'd0;
      stage_next = STG_ADDR_W;
      ph = PH_ST1;
    end
    busy = (ph != PH_IDLE);
    case (ph)
      PH_ST0: begin scl_next = 1'b0; sda_next = 1'b1; phase_next = PH_ST1; end
      PH_ST1: begin scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_ST2; end
      PH_ST2: begin scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_ST3; end
      PH_ST3: begin
        scl_next = 1'b0; sda_next = 1'b0;
        shift_reg_next = {target_address, stage == STG_ADDR_R};
        bit_count_next = 4'd0; phase_next = PH_TX0;
      end
      PH_TX0: begin scl_next = 1'b0; sda_next = shift_reg[7]; phase_next = PH_TX1; end
      PH_TX1: begin scl_next = 1'b1; sda_next = shift_reg[7]; phase_next = PH_TX2; end
      PH_TX2: begin
        scl_next = 1'b0; sda_next = shift_reg[7];
        shift_reg_next = {shift_reg[6:0], 1'b0};
        bit_count_next = bit_count + 4'd1;
        phase_next = (bit_count == 4'd7) ? PH_WA0 : PH_TX0;
      end
      PH_WA0: begin scl_next = 1'b0; sda_next = 1'b1; phase_next = PH_WA1; end
      PH_WA1: begin
        scl_next = 1'b1; sda_next = 1'b1;
        case (stage)
          STG_ADDR_W: begin
            if (tick.sda_in) begin
              error_flag_next = 1'b1; phase_next = PH_SP0;
            end else begin
              stage_next = STG_REG; shift_reg_next = saved_reg;
              bit_count_next = 4'd0; phase_next = PH_TX0;
            end
          end
          STG_REG: begin
            if (tick.sda_in) begin
              error_flag_next = 1'b1; phase_next = PH_SP0;
            end else if (read_mode) begin
              stage_next = STG_ADDR_R; phase_next = PH_ST0;
            end else begin
              stage_next = STG_WDATA; byte_count_next = '0; buf_end = 1'b1;
            end
          end
          STG_WDATA: begin
            byte_count_next = bc_inc; buf_end = 1'b1;
          end
          default: begin
            stage_next = STG_RDATA; byte_count_next = '0;
            bit_count_next = 4'd0; shift_reg_next = 8'd0;
            phase_next = (saved_length == '0) ? PH_SP0 : PH_RX0;
          end
        endcase
        // Pick the next buffered byte or go to stop once all are sent.
        if (buf_end) begin
          if (byte_count_next >= saved_length) begin
            phase_next = PH_SP0;
          end else begin
            shift_reg_next = tx_buffer[byte_count_next[IW-1:0]];
            bit_count_next = 4'd0; phase_next = PH_TX0;
          end
        end
      end
      PH_RX0: begin
        scl_next = 1'b1; sda_next = 1'b1;
        shl = {shift_reg, tick.sda_in};
        shift_reg_next = shl[7:0];
        bit_count_next = bit_count + 4'd1;
        if (bit_count == 4'd7) begin
          rdv = 1'b1; rdb = shl[7:0];
        end
        phase_next = PH_RX1;
      end
      PH_RX1: begin
        scl_next = 1'b0; sda_next = 1'b1;
        if (bit_count >= 4'd8) begin
          byte_count_next = bc_inc;
          phase_next = (bc_inc < saved_length) ? PH_AK0 : PH_NK0;
        end else begin
          phase_next = PH_RX0;
        end
      end
      PH_AK0: begin scl_next = 1'b0; sda_next = 1'b0; phase_next = PH_AK1; end
      PH_AK1: begin scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_AK2; end
      PH_AK2: begin
        scl_next = 1'b0; sda_next = 1'b0;
        bit_count_next = 4'd0; shift_reg_next = 8'd0; phase_next = PH_RX0;
      end
      PH_NK0: begin scl_next = 1'b0; sda_next = 1'b1; phase_next = PH_NK1; end
      PH_NK1: begin scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_SP0; end
      PH_SP0: begin scl_next = 1'b0; sda_next = 1'b0; phase_next = PH_SP1; end
      PH_SP1: begin scl_next = 1'b1; sda_next = 1'b0; phase_next = PH_DONE; end
      PH_DONE: begin
        scl_next = 1'b1; sda_next = 1'b1; done = 1'b1;
        guard_count_next = guard_ticks;
        phase_next = (guard_ticks != 16'd0) ? PH_GUARD : PH_IDLE;
      end
      PH_GUARD: begin
        scl_next = 1'b1; sda_next = 1'b1;
        guard_count_next = guard_count - 16'd1;
        if (guard_count <= 16'd1) begin
          guard_count_next = 16'd0; phase_next = PH_IDLE;
        end
      end
      default: begin
        scl_next = 1'b1; sda_next = 1'b1; phase_next = PH_IDLE;
      end
    endcase
  end

  assign res.scl_level  = scl_next;
  assign res.sda_level  = sda_next;
  assign res.busy_res   = busy;
  assign res.rd_byte    = rdb;
  assign res.rd_valid   = rdv;
  assign res.done_res   = done;
  assign res.nack_error = done & error_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; stage <= STG_ADDR_W;
      bit_count <= 4'd0; byte_count <= '0; shift_reg <= 8'd0;
      saved_reg <= 8'd0; saved_length <= '0; read_mode <= 1'b0;
      error_flag <= 1'b0; guard_count <= 16'd0;
      scl_reg <= 1'b1; sda_reg <= 1'b1;
    end else if (go) begin
      phase <= phase_next; stage <= stage_next;
      bit_count <= bit_count_next; byte_count <= byte_count_next;
      shift_reg <= shift_reg_next; saved_reg <= saved_reg_next;
      saved_length <= saved_length_next; read_mode <= read_mode_next;
      error_flag <= error_flag_next; guard_count <= guard_count_next;
      scl_reg <= scl_next; sda_reg <= sda_next;
    end
  end
endmodule

### design/i2crm_checker.sv
// Port-level checker for the I2C register master, bound to the top level.
// Depends only on the top level's ports.
module i2crm_props (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic rd_valid,
  input logic done_res,
  input logic nack_error,
  input logic busy_res,
  input logic scl_level,
  input logic sda_level
);
  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    !empty && nack_error |-> done_res) else $error("nack without done");
  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    !empty && done_res |-> scl_level && sda_level && busy_res)
    else $error("done tick with bus held");
  a_rd_not_done: assert property (@(posedge clk) disable iff (rst)
    !empty && rd_valid |-> !done_res && scl_level) else $error("read and done");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty) else $error("result dropped");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty && !full) else $error("queues not empty after reset");
endmodule

bind i2c_register_master i2crm_props u_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .rd_valid(rd_valid), .done_res(done_res), .nack_error(nack_error),
  .busy_res(busy_res), .scl_level(scl_level), .sda_level(sda_level)
);

### tb/sv/i2crm_checker.sv
// Checker for the I2C register master: watches the tick, result and register
// channels, predicts each result and compares all of its fields at once.
// Depends on i2crm_pkg.
`timescale 1ns / 100ps

module i2crm_checker
  import i2crm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  cmd,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  buf_index,
  input  logic [4:0]  length,
  input  logic        sda_in,
  input  logic        empty,
  input  logic        pop,
  input  logic        scl_level,
  input  logic        sda_level,
  input  logic        busy_res,
  input  logic [7:0]  rd_byte,
  input  logic        rd_valid,
  input  logic        done_res,
  input  logic        nack_error,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output logic        bus_idle,
  output int          done_seen,
  output int          nack_seen,
  output int          bytes_read
);
  typedef enum logic [4:0] {
    P_IDLE, P_ST0, P_ST1, P_ST2, P_ST3, P_TX0, P_TX1, P_TX2, P_WA0, P_WA1,
    P_RX0, P_RX1, P_AK0, P_AK1, P_AK2, P_NK0, P_NK1, P_SP0, P_SP1, P_DONE,
    P_GUARD
  } bus_phase_t;

  typedef enum logic [2:0] {
    S_ADDR_W, S_REG, S_WDATA, S_ADDR_R, S_RDATA
  } byte_stage_t;

  logic [6:0]  target_q;
  logic [15:0] guard_q;
  bus_phase_t  ph;
  byte_stage_t stg;
  logic [3:0]  nbits;
  logic [4:0]  nbytes;
  logic [7:0]  shreg;
  logic [7:0]  txbuf [MaxLenDefault];
  logic [7:0]  reg_q;
  logic [4:0]  len_q;
  logic        rd_mode, err_q, scl_q, sda_q;
  logic [15:0] guard_cnt;
  res_t        line_results [$];

  assign pending  = line_results.size();

  function automatic void load_byte(logic [7:0] v);
    shreg = v;
    nbits = 0;
    ph = P_TX0;
  endfunction

  function automatic void next_write_byte();
    if (nbytes >= len_q) ph = P_SP0;
    else load_byte(txbuf[nbytes[3:0]]);
  endfunction

  function automatic void on_ack(logic nack);
    case (stg)
      S_ADDR_W: begin
        if (nack) begin
          err_q = 1'b1;
          ph = P_SP0;
        end else begin
          stg = S_REG;
          load_byte(reg_q);
        end
      end
      S_REG: begin
        if (nack) begin
          err_q = 1'b1;
          ph = P_SP0;
        end else if (rd_mode) begin
          stg = S_ADDR_R;
          ph = P_ST0;
        end else begin
          stg = S_WDATA;
          nbytes = 0;
          next_write_byte();
        end
      end
      S_WDATA: begin
        nbytes++;
        next_write_byte();
      end
      default: begin
        // The ack of address+R is ignored; the read data starts here.
        stg = S_RDATA;
        nbytes = 0;
        nbits = 0;
        shreg = 0;
        ph = (len_q == 0) ? P_SP0 : P_RX0;
      end
    endcase
  endfunction

  function automatic res_t step_bus(tick_t t);
    res_t r;
    r = '0;
    if (ph == P_IDLE) begin
      if (t.cmd == CMD_WRITE || t.cmd == CMD_READ) begin
        reg_q = t.reg_addr;
        len_q = (t.length > MaxLenDefault) ? 5'(MaxLenDefault) : t.length;
        rd_mode = (t.cmd == CMD_READ);
        err_q = 1'b0;
        nbytes = 0;
        nbits = 0;
        stg = S_ADDR_W;
        ph = P_ST1;
      end else if (t.cmd == CMD_LOAD) begin
        txbuf[t.buf_index] = t.data_byte;
      end
    end
    r.busy_res = (ph != P_IDLE);
    case (ph)
      P_ST0: begin scl_q = 0; sda_q = 1; ph = P_ST1; end
      P_ST1: begin scl_q = 1; sda_q = 1; ph = P_ST2; end
      P_ST2: begin scl_q = 1; sda_q = 0; ph = P_ST3; end
      P_ST3: begin
        scl_q = 0; sda_q = 0;
        load_byte({target_q, stg == S_ADDR_R});
      end
      P_TX0: begin scl_q = 0; sda_q = shreg[7]; ph = P_TX1; end
      P_TX1: begin scl_q = 1; sda_q = shreg[7]; ph = P_TX2; end
      P_TX2: begin
        scl_q = 0; sda_q = shreg[7];
        shreg = shreg << 1;
        nbits++;
        ph = (nbits >= 8) ? P_WA0 : P_TX0;
      end
      P_WA0: begin scl_q = 0; sda_q = 1; ph = P_WA1; end
      P_WA1: begin scl_q = 1; sda_q = 1; on_ack(t.sda_in); end
      P_RX0: begin
        scl_q = 1; sda_q = 1;
        shreg = {shreg[6:0], t.sda_in};
        nbits++;
        if (nbits >= 8) begin
          r.rd_valid = 1'b1;
          r.rd_byte = shreg;
        end
        ph = P_RX1;
      end
      P_RX1: begin
        scl_q = 0; sda_q = 1;
        if (nbits >= 8) begin
          nbytes++;
          ph = (nbytes < len_q) ? P_AK0 : P_NK0;
        end else begin
          ph = P_RX0;
        end
      end
      P_AK0: begin scl_q = 0; sda_q = 0; ph = P_AK1; end
      P_AK1: begin scl_q = 1; sda_q = 0; ph = P_AK2; end
      P_AK2: begin
        scl_q = 0; sda_q = 0;
        nbits = 0; shreg = 0;
        ph = P_RX0;
      end
      P_NK0: begin scl_q = 0; sda_q = 1; ph = P_NK1; end
      P_NK1: begin scl_q = 1; sda_q = 1; ph = P_SP0; end
      P_SP0: begin scl_q = 0; sda_q = 0; ph = P_SP1; end
      P_SP1: begin scl_q = 1; sda_q = 0; ph = P_DONE; end
      P_DONE: begin
        scl_q = 1; sda_q = 1;
        r.done_res = 1'b1;
        r.nack_error = err_q;
        guard_cnt = guard_q;
        ph = (guard_cnt != 0) ? P_GUARD : P_IDLE;
      end
      P_GUARD: begin
        scl_q = 1; sda_q = 1;
        if (guard_cnt != 0) guard_cnt--;
        if (guard_cnt == 0) ph = P_IDLE;
      end
      default: begin
        ph = P_IDLE;
        scl_q = 1; sda_q = 1;
      end
    endcase
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_t t;
    res_t  want, got;
    if (rst) begin
      target_q = 0;
      guard_q = GuardReset;
      ph = P_IDLE;
      stg = S_ADDR_W;
      nbits = 0; nbytes = 0; shreg = 0;
      reg_q = 0; len_q = 0; rd_mode = 0; err_q = 0;
      guard_cnt = 0; scl_q = 1; sda_q = 1;
      line_results.delete();
      fail_count = 0;
      done_seen = 0; nack_seen = 0; bytes_read = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TARGET) target_q = cfg_data[6:0];
        else guard_q = cfg_data;
      end
      if (pop && !empty) begin
        got = '{scl_level, sda_level, busy_res, rd_byte, rd_valid, done_res,
                nack_error};
        if (line_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = line_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch at %0t: expected %p, got %p", $realtime, want,
                       got);
          end
          if (got.done_res) done_seen++;
          if (got.done_res && got.nack_error) nack_seen++;
          if (got.rd_valid) bytes_read++;
        end
      end
      // A tick transfer is predicted after the result side so that the queue
      // never hands back a result in the same cycle it was predicted.
      if (push && !full) begin
        t = '{cmd, reg_addr, data_byte, buf_index, length, sda_in};
        line_results.push_back(step_bus(t));
      end
    end
    // The idle flag settles after the edge, so the stimulus always reads the
    // phase as it stood before the current edge.
    bus_idle <= (ph == P_IDLE);
  end
endmodule

### tb/sv/testbench.sv
// Top of the I2C register master testbench: clock, reset, tick stimulus,
// register writes, result draining and the verdict.
// Depends on i2crm_pkg, i2crm_checker and the i2c_register_master RTL.
`timescale 1ns / 100ps

module testbench;
  import i2crm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  cmd = CMD_TICK;
  logic [7:0]  reg_addr = '0;
  logic [7:0]  data_byte = '0;
  logic [3:0]  buf_index = '0;
  logic [4:0]  length = '0;
  logic        sda_in = 1'b1;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_level, sda_level, busy_res, rd_valid, done_res, nack_error;
  logic [7:0]  rd_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_TARGET;
  logic [15:0] cfg_data = '0;

  int   fail_count, pending, done_seen, nack_seen, bytes_read;
  logic bus_idle;
  int   ticks_sent = 0;
  int   transfers_started = 0;
  int   quiet_cycles = 0;
  // Percent chance that SDA reads high on a tick of the current transfer.
  int   sda_high_pct = 0;

  localparam int QuietLimit = 2000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_register_master dut (.*);

  i2crm_checker checker_i (.*);

  // The watchdog counts cycles in which neither a tick nor a result moved.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("i2c_register_master: mismatch");
      $finish;
    end
  end

  // Result side: pops in bursts broken by gaps, mostly short and a few long.
  // Once, early in the run, it holds off long enough for both queues to fill
  // while ticks keep being offered, so full has to stall the sender.
  initial begin : drain
    int gap;
    bit long_hold_done;
    gap = 0;
    long_hold_done = 0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && push && transfers_started >= 2) begin
        long_hold_done = 1;
        gap = 400;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 99) < 15)
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  // Offers one tick transfer and holds it until accepted, then maybe idles.
  task automatic send_tick(logic [1:0] c, logic [7:0] ra, logic [7:0] db,
                           logic [3:0] bi, logic [4:0] len);
    int gap;
    push <= 1'b1;
    cmd <= c;
    reg_addr <= ra;
    data_byte <= db;
    buf_index <= bi;
    length <= len;
    sda_in <= ($urandom_range(0, 99) < sda_high_pct);
    @(posedge clk);
    while (full) @(posedge clk);
    ticks_sent++;
    if ($urandom_range(0, 99) < 12) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A command tick that the sequencer sees while busy must be ignored, so
  // random commands are sprinkled among the plain ticks of a transfer.
  task automatic noisy_tick();
    if ($urandom_range(0, 99) < 10)
      send_tick(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 4'($urandom),
                5'($urandom));
    else
      send_tick(CMD_TICK, 8'($urandom), 8'($urandom), 4'($urandom), 5'($urandom));
  endtask

  // Starts one write or read and ticks until the stop and guard gap are over.
  // The idle flag is registered behind the last accepted tick, so at least
  // one tick follows the command before it is trusted.
  task automatic run_transfer(logic [1:0] c, logic [7:0] ra, logic [4:0] len,
                              int high_pct);
    sda_high_pct = high_pct;
    transfers_started++;
    send_tick(c, ra, 8'($urandom), 4'($urandom), len);
    do
      noisy_tick();
    while (!bus_idle);
    sda_high_pct = 50;
  endtask

  // Lets every result drain and the sequencer settle before a register write.
  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    while (!bus_idle) send_tick(CMD_TICK, 8'd0, 8'd0, 4'd0, 5'd0);
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [4:0] pick_length();
    return 5'($urandom_range(0, 4));
  endfunction

  initial begin : stimulus
    logic [1:0] c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every transmit slot first so that no write ever sends a slot
    // that was never loaded. The patterns cover both values of every bit.
    for (int i = 0; i < MaxLenDefault; i++)
      send_tick(CMD_LOAD, 8'd0, (i % 2 == 1) ? 8'hFF : 8'h00, 4'(i), 5'd0);
    send_tick(CMD_LOAD, 8'd0, 8'hA5, 4'd15, 5'd0);
    send_tick(CMD_LOAD, 8'd0, 8'h5A, 4'd0, 5'd0);
    settle();

    // The address keeps its reset value of zero; a short guard keeps it brief.
    write_reg(CFG_GUARD, 16'd2);
    run_transfer(CMD_WRITE, 8'hFF, 5'd1, 100);  // address not acknowledged
    settle();

    write_reg(CFG_TARGET, 16'd127);
    write_reg(CFG_GUARD, 16'd0);
    run_transfer(CMD_WRITE, 8'h00, 5'd0, 0);    // write with no data bytes
    run_transfer(CMD_READ, 8'h3C, 5'd1, 30);
    settle();

    // Random transfers, each with its own address and guard setting.
    while (ticks_sent < 430) begin
      write_reg(CFG_TARGET, 16'($urandom_range(0, 127)));
      write_reg(CFG_GUARD, 16'($urandom_range(0, 6)));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4))
          send_tick(CMD_LOAD, 8'($urandom), 8'($urandom), 4'($urandom), 5'($urandom));
      end
      c = ($urandom_range(0, 1) == 1) ? CMD_READ : CMD_WRITE;
      run_transfer(c, 8'($urandom), pick_length(), (c == CMD_READ) ? 25 : 2);
      settle();
    end

    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d ticks over %0d transfers: %0d finished, %0d with nack error,",
             ticks_sent, transfers_started, done_seen, nack_seen);
    $display("%0d bytes read back, %0d result failures.", bytes_read, fail_count);
    if (fail_count == 0) begin
      $display("i2c_register_master: match");
    end else begin
      $display("i2c_register_master: mismatch");
    end
    $finish;
  end
endmodule

### filelist.f
design/i2crm_pkg.sv
design/i2crm_queue.sv
design/i2crm_seq.sv
design/i2c_register_master.sv
design/i2crm_checker.sv
tb/sv/i2crm_checker.sv
tb/sv/testbench.sv
